### rtl/lcq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcq_pkg
// Shared types and codes of the lap crossing qualifier: car states, entry
// layout, register indexes, operation and result codes.
// ----------------------------------------------------------------------------
package lcq_pkg;

  // Input operations
  localparam logic OP_DETECT = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // Result kinds
  localparam logic KIND_DETECT = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_MIN_LAP     = 2'd0;
  localparam logic [1:0] REG_MIN_CONFIRM = 2'd1;
  localparam logic [1:0] REG_FIRST_LAP   = 2'd2;

  // Register reset values
  localparam logic [31:0] MIN_LAP_RST     = 32'd2000;
  localparam logic [31:0] MIN_CONFIRM_RST = 32'd500;
  localparam logic        FIRST_LAP_RST   = 1'b1;

  // Per-car state codes (code 3 unused)
  localparam logic [1:0] CS_WAIT  = 2'd0;
  localparam logic [1:0] CS_CROSS = 2'd1;
  localparam logic [1:0] CS_CONF  = 2'd2;

  // Largest crossing span and most reports per tick
  localparam logic [15:0] SPAN_MAX     = 16'hFFFF;
  localparam int          REPORT_LIMIT = 16;
  localparam int          RPT_W        = $clog2(REPORT_LIMIT);

  // One car record as held in the state memory
  typedef struct packed {
    logic [1:0]  st;
    logic [31:0] ref_time;
    logic [15:0] span;
  } car_entry_t;

  localparam car_entry_t ENTRY_RST = '{st: CS_WAIT, ref_time: 32'd0, span: 16'd0};

endpackage

### rtl/lap_crossing_qualifier_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lap_crossing_qualifier_core
// Qualifies tag detections per car as lap crossings; a status tick confirms
// old-enough crossings and reports confirmed cars, earliest midpoint first.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  cfg     | in        | cfg_we             | cfg_addr, cfg_wdata
//  in      | in        | in_valid/in_ready  | operation, car_id, now_time
//  out     | out       | out_valid/out_ready| kind, new_lap, index, time, span, last
//
//  A detection does one memory read, then the update and result load.
//  A tick does one confirm sweep over the car memory, then one selection
//  sweep per reported car, as the car memory has a single read port.
//  Reset loads the configuration defaults and clears the car seen bits and
//  all control state. The block takes one item at a time; a full output
//  register stalls result loads and their memory writes, not the sweeps,
//  and in_ready is high whenever the block is idle.
// ----------------------------------------------------------------------------
module lap_crossing_qualifier_core #(
  parameter int NUM_CARS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [31:0] cfg_wdata,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_operation,
  input  wire logic [7:0]  in_car_id,
  input  wire logic [31:0] in_now_time,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_result_kind,
  output logic             out_new_lap,
  output logic [5:0]       out_car_index,
  output logic [31:0]      out_pass_time,
  output logic [15:0]      out_crossing_span,
  output logic             out_last
);

  localparam int IDX_W = (NUM_CARS > 1) ? $clog2(NUM_CARS) : 1;
  localparam int CNT_W = $clog2(NUM_CARS + 1);
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(NUM_CARS);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DWR  = 3'd1;  // detection update
  localparam logic [2:0] S_CSWP = 3'd2;  // confirm sweep
  localparam logic [2:0] S_SSWP = 3'd3;  // select sweep
  localparam logic [2:0] S_EMIT = 3'd4;  // report selected car

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [31:0] min_lap_r;
  logic [31:0] min_conf_r;
  logic        first_lap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_lap_r   <= lcq_pkg::MIN_LAP_RST;
      min_conf_r  <= lcq_pkg::MIN_CONFIRM_RST;
      first_lap_r <= lcq_pkg::FIRST_LAP_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        lcq_pkg::REG_MIN_LAP:     min_lap_r   <= cfg_wdata;
        lcq_pkg::REG_MIN_CONFIRM: min_conf_r  <= cfg_wdata;
        lcq_pkg::REG_FIRST_LAP:   first_lap_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Declarations
  // --------------------------------------------------------------------------
  logic [2:0]          st_r, st_nxt;
  logic [CNT_W-1:0]    swp_r;
  logic                p1_v_r, p2_v_r;
  logic [IDX_W-1:0]    p1_idx_r, p2_idx_r;
  lcq_pkg::car_entry_t p2_ent_r;
  logic [31:0]         p2_mid_r;
  logic                best_v_r;
  logic [IDX_W-1:0]    best_idx_r;
  lcq_pkg::car_entry_t best_ent_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [lcq_pkg::RPT_W-1:0] rpt_r;
  logic [7:0]          id_r;
  logic                id_ok_r;
  logic [31:0]         now_r;

  lcq_pkg::car_entry_t mem [NUM_CARS];
  logic [NUM_CARS-1:0] seen_r;
  lcq_pkg::car_entry_t rd_r;
  logic                rdv_r;
  logic [IDX_W-1:0]    rd_addr;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  lcq_pkg::car_entry_t mem_wdata;
  lcq_pkg::car_entry_t cur;

  logic                out_valid_r;
  logic                out_free;
  logic                in_acc;
  logic                sweep_st;
  logic                iss;

  assign in_ready = (st_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign sweep_st = (st_r == S_CSWP) || (st_r == S_SSWP);
  assign iss      = sweep_st && (swp_r != CNT_END);

  // --------------------------------------------------------------------------
  // Car memory: one write port, one registered read port
  // --------------------------------------------------------------------------
  always_comb begin
    priority if (st_r == S_IDLE) begin
      rd_addr = in_car_id[IDX_W-1:0];
    end else if (sweep_st) begin
      rd_addr = swp_r[IDX_W-1:0];
    end else begin
      rd_addr = id_r[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_r  <= mem[rd_addr];
    rdv_r <= seen_r[rd_addr];
  end

  // seen bit doubles as entry valid: only a crossing start writes a new entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else if (mem_we) begin
      seen_r[mem_waddr] <= 1'b1;
    end
  end

  // never-written entries read as reset
  assign cur = rdv_r ? rd_r : lcq_pkg::ENTRY_RST;

  // --------------------------------------------------------------------------
  // Detection update
  // --------------------------------------------------------------------------
  logic [31:0]         due;
  logic [31:0]         delta;
  logic [16:0]         span_sum;
  logic                span_fits;
  logic                det_start;
  logic                det_we;
  lcq_pkg::car_entry_t det_wr;

  assign due       = cur.ref_time + min_lap_r;
  assign delta     = now_r - cur.ref_time;
  assign span_sum  = {1'b0, cur.span} + {1'b0, delta[15:0]};
  assign span_fits = (delta[31:16] == 16'd0) && !span_sum[16];

  always_comb begin
    det_start = 1'b0;
    det_we    = 1'b0;
    det_wr    = cur;
    if (id_ok_r) begin
      unique case (cur.st)
        lcq_pkg::CS_WAIT: begin
          det_start = (first_lap_r && !rdv_r) || (due <= now_r);
          det_we    = det_start;
          det_wr    = '{st: lcq_pkg::CS_CROSS, ref_time: now_r, span: 16'd0};
        end
        lcq_pkg::CS_CROSS: begin
          det_we          = (delta != 32'd0);
          det_wr.ref_time = now_r;
          if (span_fits) begin
            det_wr.span = span_sum[15:0];
          end
        end
        default: ;  // confirmed: left alone
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Confirm stage (second stage of the confirm sweep)
  // --------------------------------------------------------------------------
  logic                cnf_hit;
  lcq_pkg::car_entry_t cnf_wr;

  assign cnf_hit = p2_v_r && (p2_ent_r.st == lcq_pkg::CS_CROSS) &&
                   ((p2_mid_r + min_conf_r) <= now_r);
  always_comb begin
    cnf_wr.st       = lcq_pkg::CS_CONF;
    cnf_wr.ref_time = p2_mid_r;
    cnf_wr.span     = (p2_ent_r.span == 16'd0) ? 16'd1 : p2_ent_r.span;
  end

  // --------------------------------------------------------------------------
  // Write port select
  // --------------------------------------------------------------------------
  logic emit_last;

  assign emit_last = (cnt_r == CNT_W'(1)) ||
                     (rpt_r == lcq_pkg::RPT_W'(lcq_pkg::REPORT_LIMIT - 1));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = id_r[IDX_W-1:0];
    mem_wdata = det_wr;
    unique case (st_r)
      S_DWR: begin
        mem_we = det_we && out_free;
      end
      S_CSWP: begin
        mem_we    = cnf_hit;
        mem_waddr = p2_idx_r;
        mem_wdata = cnf_wr;
      end
      S_EMIT: begin
        mem_we    = out_free;
        mem_waddr = best_idx_r;
        mem_wdata = '{st: lcq_pkg::CS_WAIT, ref_time: best_ent_r.ref_time,
                      span: best_ent_r.span};
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  logic cswp_done, sswp_done;

  assign cswp_done = (swp_r == CNT_END) && !p1_v_r && !p2_v_r;
  assign sswp_done = (swp_r == CNT_END) && !p1_v_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          st_nxt = (in_operation == lcq_pkg::OP_DETECT) ? S_DWR : S_CSWP;
        end
      end
      S_DWR: begin
        if (out_free) st_nxt = S_IDLE;
      end
      S_CSWP: begin
        if (cswp_done) st_nxt = S_SSWP;
      end
      S_SSWP: begin
        if (sswp_done) st_nxt = (cnt_r == '0) ? S_IDLE : S_EMIT;
      end
      S_EMIT: begin
        if (out_free) st_nxt = emit_last ? S_IDLE : S_SSWP;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      swp_r    <= '0;
      p1_v_r   <= 1'b0;
      p2_v_r   <= 1'b0;
      best_v_r <= 1'b0;
      cnt_r    <= '0;
      rpt_r    <= '0;
    end else begin
      st_r   <= st_nxt;
      p1_v_r <= iss;
      p2_v_r <= p1_v_r && (st_r == S_CSWP);
      if (iss) begin
        swp_r <= swp_r + CNT_W'(1);
      end
      // fresh sweep state on entry to a sweep
      if ((st_r == S_IDLE) || (st_r == S_CSWP) || (st_r == S_EMIT)) begin
        if (st_nxt != st_r) begin
          swp_r    <= '0;
          best_v_r <= 1'b0;
          cnt_r    <= '0;
        end
      end
      if (in_acc) begin
        rpt_r <= '0;
      end
      // selection: count confirmed cars, keep earliest (lower index on ties)
      if ((st_r == S_SSWP) && p1_v_r && (cur.st == lcq_pkg::CS_CONF)) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (!best_v_r || (cur.ref_time < best_ent_r.ref_time)) begin
          best_v_r <= 1'b1;
        end
      end
      if ((st_r == S_EMIT) && out_free) begin
        rpt_r <= rpt_r + lcq_pkg::RPT_W'(1);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      id_r    <= in_car_id;
      id_ok_r <= (32'(in_car_id) < 32'(NUM_CARS));
      now_r   <= in_now_time;
    end
    p1_idx_r <= swp_r[IDX_W-1:0];
    p2_idx_r <= p1_idx_r;
    p2_ent_r <= cur;
    p2_mid_r <= cur.ref_time - {17'd0, cur.span[15:1]};
    if ((st_r == S_SSWP) && p1_v_r && (cur.st == lcq_pkg::CS_CONF) &&
        (!best_v_r || (cur.ref_time < best_ent_r.ref_time))) begin
      best_idx_r <= p1_idx_r;
      best_ent_r <= cur;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic load_det, load_rpt;

  assign load_det = (st_r == S_DWR) && out_free;
  assign load_rpt = (st_r == S_EMIT) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_det || load_rpt) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_det) begin
      out_result_kind   <= lcq_pkg::KIND_DETECT;
      out_new_lap       <= det_start;
      out_car_index     <= id_r[5:0];
      out_pass_time     <= 32'd0;
      out_crossing_span <= 16'd0;
      out_last          <= 1'b1;
    end else if (load_rpt) begin
      out_result_kind   <= lcq_pkg::KIND_REPORT;
      out_new_lap       <= 1'b0;
      out_car_index     <= 6'(best_idx_r);
      out_pass_time     <= best_ent_r.ref_time;
      out_crossing_span <= best_ent_r.span;
      out_last          <= emit_last;
    end
  end

  assign out_valid = out_valid_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef ASSERT_OFF
  // no read of the car memory is in flight while a new item can enter
  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (!p1_v_r && !p2_v_r))
    else $error("sweep pipeline busy while idle");

  // memory writes only from the update, confirm and report steps
  a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> ((st_r == S_DWR) || (st_r == S_CSWP) || (st_r == S_EMIT)))
    else $error("car memory written outside an update step");

  // a report step always has a selected car
  a_emit_sel: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_EMIT) |-> (best_v_r && (cnt_r != '0)))
    else $error("report step without a selected car");

  // reported passages carry a nonzero span and no new-lap flag
  a_rpt_span: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_result_kind == lcq_pkg::KIND_REPORT)) |->
      ((out_crossing_span != 16'd0) && !out_new_lap))
    else $error("report with zero span");

  // a detection result is always the final beat of its item
  a_det_last: assert property (@(posedge clk) disable iff (!rst_n)
    $past(load_det) |-> (out_valid_r && out_last))
    else $error("detection result not marked last");
`endif

endmodule
`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for lap_crossing_qualifier_core. A driver pushes tag
// detections and status ticks with random bursts of idle cycles, and a
// monitor stalls the result channel at random. Every accepted beat is
// scored by a cycle-free lap model kept in the bench. Each result beat is
// checked field by field against the oldest predicted lap result.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NUM_CARS      = 16;
  localparam int CYCLE_LIMIT   = 500_000;
  // worst tick: confirm sweep plus one selection sweep per report
  localparam int SETTLE_CYCLES = (NUM_CARS + 3) * (lcq_pkg::REPORT_LIMIT + 1) + 50;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic        op;
    logic [7:0]  car_id;
    logic [31:0] now_t;
  } tag_event_t;

  typedef struct packed {
    logic        kind;
    logic        new_lap;
    logic [5:0]  car_index;
    logic [31:0] pass_t;
    logic [15:0] span;
    logic        last;
  } lap_result_t;

  // DUT ports
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = lcq_pkg::REG_MIN_LAP;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  wire         in_ready;
  logic        in_operation = lcq_pkg::OP_DETECT;
  logic [7:0]  in_car_id = '0;
  logic [31:0] in_now_time = '0;
  wire         out_valid;
  logic        out_ready = 1'b0;
  wire         out_result_kind;
  wire         out_new_lap;
  wire [5:0]   out_car_index;
  wire [31:0]  out_pass_time;
  wire [15:0]  out_crossing_span;
  wire         out_last;

  // lap model state and register shadows
  logic [1:0]  car_st   [NUM_CARS];
  logic [31:0] car_mark [NUM_CARS];
  logic [15:0] car_span [NUM_CARS];
  bit          car_seen [NUM_CARS];
  logic [31:0] lap_min;
  logic [31:0] confirm_min;
  logic        first_lap_en;

  tag_event_t  event_q[$];
  lap_result_t lap_result_q[$];
  tag_event_t  next_event;
  lap_result_t want;

  logic        in_took = 1'b0;
  bit          calm_run = 1'b0;
  int          in_gap = 0;
  int          out_gap = 0;
  int          mismatch_count = 0;
  int          gen_count = 0;
  int          cycle_count = 0;
  logic [31:0] race_clock;

  lap_crossing_qualifier_core #(.NUM_CARS(NUM_CARS)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_car_id        (in_car_id),
    .in_now_time      (in_now_time),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_kind  (out_result_kind),
    .out_new_lap      (out_new_lap),
    .out_car_index    (out_car_index),
    .out_pass_time    (out_pass_time),
    .out_crossing_span(out_crossing_span),
    .out_last         (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // One mismatch: count it and print one line
  task automatic flag_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Lap model: score one accepted beat, queue the lap results it causes
  task automatic qualify_item(input logic op, input logic [7:0] car_id,
                              input logic [31:0] now_t);
    logic        new_lap;
    logic [31:0] delta;
    logic [31:0] mid;
    lap_result_t r;
    int          c;
    int          i;
    int          k;
    int          best;
    int          n_conf;
    int          n_rep;
    if (op == lcq_pkg::OP_DETECT) begin
      new_lap = 1'b0;
      if (car_id < NUM_CARS) begin
        c = car_id;
        if (car_st[c] == lcq_pkg::CS_WAIT) begin
          if ((first_lap_en && !car_seen[c]) || (car_mark[c] + lap_min <= now_t)) begin
            car_mark[c] = now_t;
            car_span[c] = '0;
            car_st[c]   = lcq_pkg::CS_CROSS;
            car_seen[c] = 1'b1;
            new_lap     = 1'b1;
          end
        end else if (car_st[c] == lcq_pkg::CS_CROSS) begin
          delta = now_t - car_mark[c];
          if (delta != 32'd0) begin
            car_mark[c] = now_t;
            // add is dropped when it would overflow the span
            if (delta <= {16'd0, lcq_pkg::SPAN_MAX - car_span[c]})
              car_span[c] = car_span[c] + delta[15:0];
          end
        end
      end
      r.kind      = lcq_pkg::KIND_DETECT;
      r.new_lap   = new_lap;
      r.car_index = car_id[5:0];
      r.pass_t    = '0;
      r.span      = '0;
      r.last      = 1'b1;
      lap_result_q.push_back(r);
    end else begin
      // confirm crossings whose midpoint is old enough
      for (i = 0; i < NUM_CARS; i++) begin
        if (car_st[i] == lcq_pkg::CS_CROSS) begin
          mid = car_mark[i] - {17'd0, car_span[i][15:1]};
          if (mid + confirm_min <= now_t) begin
            if (car_span[i] == 16'd0) car_span[i] = 16'd1;
            car_mark[i] = mid;
            car_st[i]   = lcq_pkg::CS_CONF;
          end
        end
      end
      n_conf = 0;
      for (i = 0; i < NUM_CARS; i++)
        if (car_st[i] == lcq_pkg::CS_CONF) n_conf++;
      n_rep = (n_conf > lcq_pkg::REPORT_LIMIT) ? lcq_pkg::REPORT_LIMIT : n_conf;
      // report earliest midpoint first, lower index wins a tie
      for (k = 0; k < n_rep; k++) begin
        best = -1;
        for (i = 0; i < NUM_CARS; i++) begin
          if (car_st[i] == lcq_pkg::CS_CONF) begin
            if (best < 0) best = i;
            else if (car_mark[i] < car_mark[best]) best = i;
          end
        end
        r.kind      = lcq_pkg::KIND_REPORT;
        r.new_lap   = 1'b0;
        r.car_index = best[5:0];
        r.pass_t    = car_mark[best];
        r.span      = car_span[best];
        r.last      = (k == n_rep - 1);
        lap_result_q.push_back(r);
        car_st[best] = lcq_pkg::CS_WAIT;
      end
    end
  endtask

  // Register write while idle; shadow follows at once
  task automatic set_register(input logic [1:0] addr, input logic [31:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (addr)
      lcq_pkg::REG_MIN_LAP:     lap_min      = data;
      lcq_pkg::REG_MIN_CONFIRM: confirm_min  = data;
      lcq_pkg::REG_FIRST_LAP:   first_lap_en = data[0];
      default: ;
    endcase
  endtask

  task automatic add_event(input logic op, input logic [7:0] car_id,
                           input logic [31:0] now_t);
    tag_event_t ev;
    ev.op     = op;
    ev.car_id = car_id;
    ev.now_t  = now_t;
    event_q.push_back(ev);
    gen_count++;
  endtask

  // One lap round: a few cars cross the loop, then one or two ticks
  task automatic lap_round();
    int base_car;
    int n_cars;
    int n_det;
    race_clock += 32'($urandom_range(0, 4000));
    if ($urandom_range(0, 9) == 0) race_clock = 32'hFFFF_FFFF - 32'($urandom_range(0, 300));
    base_car = $urandom_range(0, NUM_CARS - 1);
    n_cars   = $urandom_range(1, 5);
    n_det    = $urandom_range(2, 10);
    repeat (n_det) begin
      if ($urandom_range(0, 11) == 0) race_clock += 32'($urandom_range(16'h4000, 32'h2_0000));
      else if ($urandom_range(0, 7) != 0) race_clock += 32'($urandom_range(1, 80));
      add_event(lcq_pkg::OP_DETECT,
                8'((base_car + $urandom_range(0, n_cars - 1)) % NUM_CARS), race_clock);
    end
    race_clock += 32'($urandom_range(0, 1500));
    add_event(lcq_pkg::OP_TICK, 8'($urandom), race_clock);
    if ($urandom_range(0, 3) == 0) begin
      race_clock += 32'($urandom_range(200, 1500));
      add_event(lcq_pkg::OP_TICK, 8'($urandom), race_clock);
    end
  endtask

  // Wait for the block to go quiet: nothing pending, nothing owed
  task automatic wait_drained();
    while (event_q.size() != 0 || in_valid || lap_result_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int n_items);
    int target;
    target = gen_count + n_items;
    while (gen_count < target) begin
      if ($urandom_range(0, 4) == 0)
        add_event(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), $urandom);
      else
        lap_round();
    end
    wait_drained();
  endtask

  // Cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Input driver: next beat at the falling edge once the last one is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (event_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (!calm_run && $urandom_range(0, 5) == 0) begin
        in_gap = $urandom_range(0, 4);
        in_valid <= 1'b0;
      end else begin
        next_event = event_q.pop_front();
        in_valid     <= 1'b1;
        in_operation <= next_event.op;
        in_car_id    <= next_event.car_id;
        in_now_time  <= next_event.now_t;
      end
    end
  end

  // Accepted input beat goes through the lap model
  always @(posedge clk) begin
    in_took <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready)
      qualify_item(in_operation, in_car_id, in_now_time);
  end

  // Result-side backpressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else if (!calm_run && $urandom_range(0, 6) == 0) begin
      out_gap = $urandom_range(0, 4);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (lap_result_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected beat, car %0d kind %0d",
                                out_car_index, out_result_kind));
      end else begin
        want = lap_result_q.pop_front();
        if (out_result_kind !== want.kind)
          flag_mismatch($sformatf("result_kind %0d, want %0d", out_result_kind, want.kind));
        if (out_new_lap !== want.new_lap)
          flag_mismatch($sformatf("new_lap %0d, want %0d", out_new_lap, want.new_lap));
        if (out_car_index !== want.car_index)
          flag_mismatch($sformatf("car_index %0d, want %0d", out_car_index, want.car_index));
        if (out_pass_time !== want.pass_t)
          flag_mismatch($sformatf("pass_time %h, want %h", out_pass_time, want.pass_t));
        if (out_crossing_span !== want.span)
          flag_mismatch($sformatf("crossing_span %h, want %h", out_crossing_span, want.span));
        if (out_last !== want.last)
          flag_mismatch($sformatf("last %0d, want %0d", out_last, want.last));
      end
    end
  end

  // Stimulus and run control
  initial begin
    lap_min      = lcq_pkg::MIN_LAP_RST;
    confirm_min  = lcq_pkg::MIN_CONFIRM_RST;
    first_lap_en = lcq_pkg::FIRST_LAP_RST;
    for (int i = 0; i < NUM_CARS; i++) begin
      car_st[i]   = lcq_pkg::CS_WAIT;
      car_mark[i] = '0;
      car_span[i] = '0;
      car_seen[i] = 1'b0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: first lap, zero delta, ignored ids, midpoint tie
    add_event(lcq_pkg::OP_DETECT, 8'd0, 32'd1000);
    add_event(lcq_pkg::OP_DETECT, 8'd0, 32'd1000);
    add_event(lcq_pkg::OP_DETECT, 8'd0, 32'd1010);
    add_event(lcq_pkg::OP_DETECT, 8'd15, 32'd1005);
    add_event(lcq_pkg::OP_DETECT, 8'd16, 32'd1020);
    add_event(lcq_pkg::OP_DETECT, 8'd255, 32'd1020);
    add_event(lcq_pkg::OP_DETECT, 8'd1, 32'd1003);
    add_event(lcq_pkg::OP_DETECT, 8'd1, 32'd1013);
    add_event(lcq_pkg::OP_TICK, 8'd0, 32'd1200);
    add_event(lcq_pkg::OP_TICK, 8'd0, 32'd1600);
    // lap time not yet due, then due exactly
    add_event(lcq_pkg::OP_DETECT, 8'd0, 32'd2000);
    race_clock = 32'd3005;
    add_event(lcq_pkg::OP_DETECT, 8'd0, race_clock);
    // span fills up, overflowing add dropped, exact 0xFFFF kept
    race_clock += 32'hFFF0;
    add_event(lcq_pkg::OP_DETECT, 8'd0, race_clock);
    race_clock += 32'h20;
    add_event(lcq_pkg::OP_DETECT, 8'd0, race_clock);
    race_clock += 32'hF;
    add_event(lcq_pkg::OP_DETECT, 8'd0, race_clock);
    // midpoint at the top of the time range, confirmed across the wrap
    add_event(lcq_pkg::OP_DETECT, 8'd2, 32'hFFFF_FFFF);
    add_event(lcq_pkg::OP_TICK, 8'd0, 32'd600);
    add_event(lcq_pkg::OP_TICK, 8'hA5, 32'hFFFF_FFFF);
    wait_drained();

    // never-seen car must wait out the lap time without the first-lap option
    set_register(lcq_pkg::REG_FIRST_LAP, 32'd0);
    add_event(lcq_pkg::OP_DETECT, 8'd9, 32'd100);
    add_event(lcq_pkg::OP_DETECT, 8'd9, 32'd2000);
    add_event(lcq_pkg::OP_DETECT, 8'd12, 32'd2000);
    add_event(lcq_pkg::OP_TICK, 8'd0, 32'd2500);
    wait_drained();

    // register extremes, low then high
    race_clock = 32'd10000;
    set_register(lcq_pkg::REG_MIN_LAP, 32'd0);
    set_register(lcq_pkg::REG_MIN_CONFIRM, 32'd0);
    set_register(lcq_pkg::REG_FIRST_LAP, 32'hFFFF_FFFE);
    set_register(REG_UNUSED, $urandom);
    run_phase(30);
    set_register(lcq_pkg::REG_MIN_LAP, 32'hFFFF_FFFF);
    set_register(lcq_pkg::REG_MIN_CONFIRM, 32'hFFFF_FFFF);
    set_register(lcq_pkg::REG_FIRST_LAP, 32'd1);
    run_phase(30);

    // typical settings
    repeat (2) begin
      set_register(lcq_pkg::REG_MIN_LAP, 32'($urandom_range(0, 3000)));
      set_register(lcq_pkg::REG_MIN_CONFIRM, 32'($urandom_range(0, 1200)));
      set_register(lcq_pkg::REG_FIRST_LAP, $urandom);
      run_phase(35);
    end

    // closing stretch at full rate on both sides
    set_register(lcq_pkg::REG_MIN_LAP, 32'($urandom_range(0, 3000)));
    set_register(lcq_pkg::REG_MIN_CONFIRM, 32'($urandom_range(0, 1200)));
    set_register(lcq_pkg::REG_FIRST_LAP, $urandom);
    calm_run = 1'b1;
    run_phase(40);

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/lcq_pkg.sv
rtl/lap_crossing_qualifier_core.sv
tb/tb_top.sv
